>>> rtl/core/hrpl_pkg.sv
// ----------------------------------------------------------------------------
// hrpl_pkg
// shared sizes, codes, structs and helpers of the hex record page loader
// ----------------------------------------------------------------------------
`default_nettype none

package hrpl_pkg;

  localparam int PAGE_BYTES   = 128;
  localparam int RECORD_BYTES = 16;
  localparam int PAGE_WORDS   = (PAGE_BYTES + 1) / 2;
  localparam int PW_AW        = (PAGE_WORDS > 1) ? $clog2(PAGE_WORDS) : 1;
  localparam int PB_W         = $clog2(PAGE_BYTES + 1);
  localparam int RB_AW        = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam int RB_CW        = $clog2(RECORD_BYTES + 1);
  localparam int CFG_IW       = 3;

  // configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_START_CODE   = 3'd0,
    CFG_READY_CODE   = 3'd1,
    CFG_RESEND_CODE  = 3'd2,
    CFG_FINAL_TYPE   = 3'd3,
    CFG_BASE_ADDRESS = 3'd4
  } cfg_idx_t;

  // record parse phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_ADDR_A,
    PH_ADDR_B,
    PH_TYPE,
    PH_DATA,
    PH_CSUM,
    PH_OVER
  } phase_t;

  // sequencer state
  typedef enum logic [2:0] {
    SQ_PARSE,
    SQ_READY,
    SQ_COPY_RD,
    SQ_COPY_WR,
    SQ_COPY_DONE,
    SQ_FLUSH_RD,
    SQ_FLUSH_WR
  } seq_t;

  typedef struct packed {
    logic [7:0]  start_code;
    logic [7:0]  ready_code;
    logic [7:0]  resend_code;
    logic [7:0]  final_type;
    logic [15:0] base_address;
  } cfg_t;

  typedef struct packed {
    logic             wr_en;
    logic [RB_AW-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [RB_AW-1:0] rd_addr;
  } rec_cmd_t;

  typedef struct packed {
    logic             clear;
    logic             wr_en;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [PW_AW-1:0] rd_word;
  } pg_cmd_t;

  typedef struct packed {
    logic [PB_W-1:0] fill;
    logic            full;
    logic [15:0]     rd_data;
  } pg_stat_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        word_valid;
    logic [15:0] word_address;
    logic [15:0] flash_word;
    logic        page_end;
    logic        image_end;
    logic        last;
  } res_t;

  // reply-only result
  function automatic res_t mk_tx(input logic [7:0] code, input logic last);
    res_t r;
    r          = '0;
    r.tx_valid = 1'b1;
    r.tx_byte  = code;
    r.last     = last;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/hrpl_rec_store.sv
// ----------------------------------------------------------------------------
// hrpl_rec_store
// record data buffer, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hrpl_rec_store
  import hrpl_pkg::*;
(
  input  wire logic     clk,
  input  wire rec_cmd_t cmd,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [RECORD_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/core/hrpl_page_store.sv
// ----------------------------------------------------------------------------
// hrpl_page_store
// page memory in 16-bit words with byte writes at the fill point
// ----------------------------------------------------------------------------
`default_nettype none

module hrpl_page_store
  import hrpl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire pg_cmd_t cmd,
  output pg_stat_t     stat
);

  logic [15:0]      mem [PAGE_WORDS];
  logic [15:0]      raw_r;
  logic             lo_ok_r;
  logic             hi_ok_r;
  logic [PB_W-1:0]  fill_r;
  logic [PB_W-1:0]  fill_nxt;
  logic             full;
  logic             wr_go;
  logic [PW_AW-1:0] wr_word;
  logic [PB_W:0]    rd_lo_idx;

  assign full      = (fill_r >= PB_W'(PAGE_BYTES));
  assign wr_go     = cmd.wr_en && !full;
  assign wr_word   = PW_AW'(fill_r >> 1);
  assign rd_lo_idx = (PB_W + 1)'({cmd.rd_word, 1'b0});

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.clear) begin
      fill_nxt = '0;
    end else if (wr_go) begin
      fill_nxt = fill_r + PB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // bytes at or past the fill count read as zero, so no clearing pass
  always_ff @(posedge clk) begin
    if (wr_go && !fill_r[0]) begin
      mem[wr_word][7:0] <= cmd.wr_data;
    end
    if (wr_go && fill_r[0]) begin
      mem[wr_word][15:8] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      raw_r   <= mem[cmd.rd_word];
      lo_ok_r <= rd_lo_idx < (PB_W + 1)'(fill_r);
      hi_ok_r <= (rd_lo_idx + (PB_W + 1)'(1)) < (PB_W + 1)'(fill_r);
    end
  end

  assign stat.fill    = fill_r;
  assign stat.full    = full;
  assign stat.rd_data = {hi_ok_r ? raw_r[15:8] : 8'd0, lo_ok_r ? raw_r[7:0] : 8'd0};

endmodule

`default_nettype wire

>>> rtl/core/hrpl_ctrl.sv
// ----------------------------------------------------------------------------
// hrpl_ctrl
// record parser, commit and flush sequencer, result register
// ----------------------------------------------------------------------------
`default_nettype none

module hrpl_ctrl
  import hrpl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_kind,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output res_t            out_res,
  output rec_cmd_t        rec_cmd,
  input  wire logic [7:0] rec_rd_data,
  output pg_cmd_t         pg_cmd,
  input  wire pg_stat_t   pg_stat
);

  phase_t           phase_r, phase_nxt;
  seq_t             seq_r, seq_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [15:0]      flash_r, flash_nxt;
  logic [RB_CW-1:0] copy_r, copy_nxt;
  logic [PW_AW-1:0] word_r, word_nxt;
  logic             with_ready_r, with_ready_nxt;
  logic             final_r, final_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_r, out_nxt;
  logic             out_free;
  logic             accept;
  logic             endw;
  logic [7:0]       csum_exp;
  logic [8:0]       cnt_inc;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (seq_r != SQ_PARSE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign endw     = (word_r == PW_AW'(PAGE_WORDS - 1));
  assign csum_exp = 8'(8'd0 - sum_r);
  assign cnt_inc  = {1'b0, cnt_r} + 9'd1;

  always_comb begin
    phase_nxt      = phase_r;
    seq_nxt        = seq_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    type_nxt       = type_r;
    flash_nxt      = flash_r;
    copy_nxt       = copy_r;
    word_nxt       = word_r;
    with_ready_nxt = with_ready_r;
    final_nxt      = final_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    rec_cmd        = '0;
    pg_cmd         = '0;

    case (seq_r)
      SQ_PARSE: begin
        if (accept && in_kind) begin
          // new session: drop record and page
          pg_cmd.clear  = 1'b1;
          flash_nxt     = cfg.base_address;
          phase_nxt     = PH_IDLE;
          len_nxt       = '0;
          cnt_nxt       = '0;
          sum_nxt       = '0;
          type_nxt      = '0;
          out_valid_nxt = 1'b1;
          out_nxt       = mk_tx(cfg.ready_code, 1'b1);
        end else if (accept) begin
          case (phase_r)
            PH_IDLE: begin
              if (in_rx_byte == cfg.start_code) begin
                phase_nxt = PH_LEN;
                sum_nxt   = '0;
                cnt_nxt   = '0;
              end
            end
            PH_LEN: begin
              len_nxt   = in_rx_byte;
              sum_nxt   = in_rx_byte;
              phase_nxt = PH_ADDR_A;
            end
            PH_ADDR_A: begin
              sum_nxt   = sum_r + in_rx_byte;
              phase_nxt = PH_ADDR_B;
            end
            PH_ADDR_B: begin
              sum_nxt   = sum_r + in_rx_byte;
              phase_nxt = PH_TYPE;
            end
            PH_TYPE: begin
              type_nxt  = in_rx_byte;
              phase_nxt = (len_r != 8'd0) ? PH_DATA : PH_CSUM;
            end
            PH_DATA: begin
              if (cnt_r < 8'(RECORD_BYTES)) begin
                rec_cmd.wr_en   = 1'b1;
                rec_cmd.wr_addr = cnt_r[RB_AW-1:0];
                rec_cmd.wr_data = in_rx_byte;
              end
              sum_nxt = sum_r + in_rx_byte;
              cnt_nxt = cnt_inc[7:0];
              if (cnt_inc >= {1'b0, len_r}) begin
                phase_nxt = PH_CSUM;
              end
            end
            PH_CSUM: begin
              phase_nxt = PH_IDLE;
              if (type_r == cfg.final_type) begin
                // final record: flush whole page, no reply
                phase_nxt      = PH_OVER;
                with_ready_nxt = 1'b0;
                final_nxt      = 1'b1;
                word_nxt       = '0;
                seq_nxt        = SQ_FLUSH_RD;
              end else if (len_r > 8'(RECORD_BYTES) || csum_exp != in_rx_byte) begin
                out_valid_nxt = 1'b1;
                out_nxt       = mk_tx(cfg.resend_code, 1'b0);
                seq_nxt       = SQ_READY;
              end else if (len_r == 8'd0) begin
                out_valid_nxt = 1'b1;
                out_nxt       = mk_tx(cfg.ready_code, 1'b1);
              end else begin
                copy_nxt = '0;
                seq_nxt  = SQ_COPY_RD;
              end
            end
            PH_OVER: begin
              // session over, bytes ignored
            end
            default: begin
            end
          endcase
        end
      end
      SQ_READY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = mk_tx(cfg.ready_code, 1'b1);
          seq_nxt       = SQ_PARSE;
        end
      end
      SQ_COPY_RD: begin
        rec_cmd.rd_en   = 1'b1;
        rec_cmd.rd_addr = copy_r[RB_AW-1:0];
        seq_nxt         = SQ_COPY_WR;
      end
      SQ_COPY_WR: begin
        pg_cmd.wr_en   = 1'b1;
        pg_cmd.wr_data = rec_rd_data;
        copy_nxt       = copy_r + RB_CW'(1);
        seq_nxt        = (8'(copy_r) + 8'd1 == len_r) ? SQ_COPY_DONE : SQ_COPY_RD;
      end
      SQ_COPY_DONE: begin
        if (pg_stat.full) begin
          with_ready_nxt = 1'b1;
          final_nxt      = 1'b0;
          word_nxt       = '0;
          seq_nxt        = SQ_FLUSH_RD;
        end else begin
          seq_nxt = SQ_READY;
        end
      end
      SQ_FLUSH_RD: begin
        pg_cmd.rd_en   = 1'b1;
        pg_cmd.rd_word = word_r;
        seq_nxt        = SQ_FLUSH_WR;
      end
      SQ_FLUSH_WR: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt              = '0;
          out_nxt.tx_valid     = with_ready_r && endw;
          out_nxt.tx_byte      = (with_ready_r && endw) ? cfg.ready_code : 8'd0;
          out_nxt.word_valid   = 1'b1;
          out_nxt.word_address = flash_r + 16'({word_r, 1'b0});
          out_nxt.flash_word   = pg_stat.rd_data;
          out_nxt.page_end     = endw;
          out_nxt.image_end    = final_r;
          out_nxt.last         = endw;
          if (endw) begin
            pg_cmd.clear = 1'b1;
            flash_nxt    = flash_r + 16'(PAGE_BYTES);
            seq_nxt      = SQ_PARSE;
          end else begin
            word_nxt = word_r + PW_AW'(1);
            seq_nxt  = SQ_FLUSH_RD;
          end
        end
      end
      default: begin
        seq_nxt = SQ_PARSE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      seq_r       <= SQ_PARSE;
      len_r       <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      type_r      <= '0;
      flash_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      seq_r       <= seq_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      type_r      <= type_nxt;
      flash_r     <= flash_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    copy_r       <= copy_nxt;
    word_r       <= word_nxt;
    with_ready_r <= with_ready_nxt;
    final_r      <= final_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire

>>> rtl/core/hex_record_page_loader_top.sv
// ----------------------------------------------------------------------------
// hex_record_page_loader_top
// binary hex record receiver that assembles flash pages and emits words
// ----------------------------------------------------------------------------
// Each input transaction carries one received link byte (kind 0) or a
// session restart (kind 1). Records are start code, length, two address
// bytes, type, data and checksum; a good record's data is appended to the
// page memory and answered with the ready code, a bad or over-long record
// (length above 16) gets the resend code and then ready. A full page, or a
// record of the final type, is emitted as one result per 16-bit little-endian
// word with its flash byte address; the last word of the page carries
// page_end and last, and on a full-page flush also the ready reply. A good
// record is committed by a copy sweep over its data bytes, each a record
// buffer read and then a page memory write. A page flush reads the page
// memory through its single read port, one word after another, for the 64
// words. No input is taken while a commit or flush runs or while the
// result register is stalled. The page memory needs no clearing pass after
// reset: bytes beyond the fill count read as zero. Configuration writes are
// always taken (cfg_ready stays high) and belong in idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_record_page_loader_top
  import hrpl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input transactions
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_kind,
  input  wire logic [7:0]        in_rx_byte,
  // result transactions
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_tx_valid,
  output logic [7:0]             out_tx_byte,
  output logic                   out_word_valid,
  output logic [15:0]            out_word_address,
  output logic [15:0]            out_flash_word,
  output logic                   out_page_end,
  output logic                   out_image_end,
  output logic                   out_last,
  // configuration writes
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [15:0]       cfg_data
);

  cfg_t     cfg_r, cfg_nxt;
  res_t     res;
  rec_cmd_t rec_cmd;
  logic [7:0] rec_rd_data;
  pg_cmd_t  pg_cmd;
  pg_stat_t pg_stat;

  // config registers, writes beyond the list are dropped
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_CODE:   cfg_nxt.start_code   = cfg_data[7:0];
        CFG_READY_CODE:   cfg_nxt.ready_code   = cfg_data[7:0];
        CFG_RESEND_CODE:  cfg_nxt.resend_code  = cfg_data[7:0];
        CFG_FINAL_TYPE:   cfg_nxt.final_type   = cfg_data[7:0];
        CFG_BASE_ADDRESS: cfg_nxt.base_address = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code   <= 8'd58;
      cfg_r.ready_code   <= 8'd10;
      cfg_r.resend_code  <= 8'd11;
      cfg_r.final_type   <= 8'd1;
      cfg_r.base_address <= 16'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // parser and commit / flush sequencer
  hrpl_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_rx_byte  (in_rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (res),
    .rec_cmd     (rec_cmd),
    .rec_rd_data (rec_rd_data),
    .pg_cmd      (pg_cmd),
    .pg_stat     (pg_stat)
  );

  // data bytes of the record being received
  hrpl_rec_store u_rec (
    .clk     (clk),
    .cmd     (rec_cmd),
    .rd_data (rec_rd_data)
  );

  // page being assembled, with its fill count
  hrpl_page_store u_page (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (pg_cmd),
    .stat  (pg_stat)
  );

  assign out_tx_valid     = res.tx_valid;
  assign out_tx_byte      = res.tx_byte;
  assign out_word_valid   = res.word_valid;
  assign out_word_address = res.word_address;
  assign out_flash_word   = res.flash_word;
  assign out_page_end     = res.page_end;
  assign out_image_end    = res.image_end;
  assign out_last         = res.last;

endmodule

`default_nettype wire

>>> rtl/core/hrpl_checker.sv
// ----------------------------------------------------------------------------
// hrpl_checker
// port-level checks of the hex record page loader, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module hrpl_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_tx_valid,
  input wire logic [7:0]  out_tx_byte,
  input wire logic        out_word_valid,
  input wire logic [15:0] out_word_address,
  input wire logic [15:0] out_flash_word,
  input wire logic        out_page_end,
  input wire logic        out_image_end,
  input wire logic        out_last
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_byte)
      && $stable(out_flash_word) && $stable(out_word_address) && $stable(out_last))
    else $error("stalled result changed");

  // the page-ending word closes the results of its input
  a_page_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word_valid && out_page_end |-> out_last)
    else $error("page end word not marked last");

  // a result without a word is a reply
  a_reply_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word_valid |-> out_tx_valid && out_word_address == 16'd0
      && out_flash_word == 16'd0 && !out_page_end && !out_image_end)
    else $error("reply result carries word fields");

  // final page flush sends no reply
  a_final_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_end |-> !out_tx_valid && out_word_valid)
    else $error("reply on final page");

  // a word result other than the page end is never last and carries no reply
  a_mid_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word_valid && !out_page_end |-> !out_last && !out_tx_valid)
    else $error("mid-page word marked last or carries reply");

endmodule

bind hex_record_page_loader_top hrpl_checker u_hrpl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_tx_valid     (out_tx_valid),
  .out_tx_byte      (out_tx_byte),
  .out_word_valid   (out_word_valid),
  .out_word_address (out_word_address),
  .out_flash_word   (out_flash_word),
  .out_page_end     (out_page_end),
  .out_image_end    (out_image_end),
  .out_last         (out_last)
);

`default_nettype wire

>>> tb/sv/hex_record_page_loader_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_record_page_loader_top_tb
// self-checking bench for the hex record page loader
// ----------------------------------------------------------------------------
// Link bytes and session restarts are pushed into the loader as framed records
// (good, bad checksum, over-long, cut short, final type) and as stray noise.
// A behavioral copy of the record parser and page memory runs beside the
// design and queues the replies and flash words each transaction should cause.
// Every result transaction is compared field by field with the oldest queued
// entry. Register settings are switched between phases while the loader is
// idle, and both channels are throttled at random in several patterns.
// ----------------------------------------------------------------------------

module hex_record_page_loader_top_tb;
  import hrpl_pkg::*;

  typedef logic [7:0] link_bytes_t [$];

  // register values after reset
  localparam logic [7:0]  DEF_START  = 8'd58;
  localparam logic [7:0]  DEF_READY  = 8'd10;
  localparam logic [7:0]  DEF_RESEND = 8'd11;
  localparam logic [7:0]  DEF_FINAL  = 8'd1;
  localparam logic [15:0] DEF_BASE   = 16'h0000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_kind = 1'b0;
  logic [7:0]          in_rx_byte = 8'h00;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_tx_valid;
  logic [7:0]          out_tx_byte;
  logic                out_word_valid;
  logic [15:0]         out_word_address;
  logic [15:0]         out_flash_word;
  logic                out_page_end;
  logic                out_image_end;
  logic                out_last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [15:0]         cfg_data = '0;

  hex_record_page_loader_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tx_valid     (out_tx_valid),
    .out_tx_byte      (out_tx_byte),
    .out_word_valid   (out_word_valid),
    .out_word_address (out_word_address),
    .out_flash_word   (out_flash_word),
    .out_page_end     (out_page_end),
    .out_image_end    (out_image_end),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 8 ns clock, first rising edge at 4 ns
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // behavioral copy of the loader: registers, parser state and page memory
  // --------------------------------------------------------------------------
  logic [7:0]  code_start, code_ready, code_resend, code_final;
  logic [15:0] base_addr;
  phase_t      rec_phase;
  logic [7:0]  rec_len, rec_count, rec_sum, rec_type;
  logic [7:0]  rec_buf [RECORD_BYTES];
  logic [7:0]  page_buf [PAGE_BYTES];
  int          page_fill;
  logic [15:0] flash_addr;

  // replies and flash words still owed by the design, oldest first
  res_t reply_word_q [$];

  // run bookkeeping
  int errors = 0;
  int link_count = 0;
  int result_count = 0;
  int word_count = 0;
  int cfg_count = 0;

  // throttle knobs, percent per cycle
  int idle_pct = 0;
  int stall_pct = 0;

  // codes the stimulus needs to frame records under the current settings
  logic [7:0] cur_start = DEF_START;
  logic [7:0] cur_final = DEF_FINAL;

  task automatic clear_page();
    foreach (page_buf[k]) page_buf[k] = 8'h00;
    page_fill = 0;
  endtask

  task automatic push_reply(input logic [7:0] code);
    res_t r;
    r = '0;
    r.tx_valid = 1'b1;
    r.tx_byte = code;
    reply_word_q.push_back(r);
  endtask

  // one result per 16-bit word, low byte from the even address
  task automatic emit_page(input bit with_ready, input bit final_page);
    res_t r;
    for (int w = 0; w < PAGE_WORDS; w++) begin
      r = '0;
      r.word_valid = 1'b1;
      r.word_address = flash_addr + 16'(2 * w);
      r.flash_word = {(2 * w + 1 < PAGE_BYTES) ? page_buf[2 * w + 1] : 8'h00, page_buf[2 * w]};
      r.page_end = (w == PAGE_WORDS - 1);
      r.image_end = final_page;
      // a full-page flush carries the ready reply on its last word
      if (with_ready && r.page_end) begin
        r.tx_valid = 1'b1;
        r.tx_byte = code_ready;
      end
      reply_word_q.push_back(r);
    end
    flash_addr = flash_addr + 16'(PAGE_BYTES);
    clear_page();
  endtask

  task automatic reset_loader_copy();
    code_start = DEF_START;
    code_ready = DEF_READY;
    code_resend = DEF_RESEND;
    code_final = DEF_FINAL;
    base_addr = DEF_BASE;
    rec_phase = PH_IDLE;
    rec_len = '0;
    rec_count = '0;
    rec_sum = '0;
    rec_type = '0;
    foreach (rec_buf[k]) rec_buf[k] = 8'h00;
    clear_page();
    flash_addr = '0;
  endtask

  task automatic parse_link_byte(input logic kind, input logic [7:0] b);
    int owed_before;
    owed_before = reply_word_q.size();
    if (kind) begin
      // restart: drop partial record and page, rewind to base, say ready
      clear_page();
      flash_addr = base_addr;
      rec_phase = PH_IDLE;
      rec_len = '0;
      rec_count = '0;
      rec_sum = '0;
      rec_type = '0;
      push_reply(code_ready);
    end else begin
      case (rec_phase)
        PH_IDLE: begin
          if (b == code_start) begin
            rec_phase = PH_LEN;
            rec_sum = '0;
            rec_count = '0;
          end
        end
        PH_LEN: begin
          rec_len = b;
          rec_sum = b;
          rec_phase = PH_ADDR_A;
        end
        PH_ADDR_A: begin
          rec_sum += b;
          rec_phase = PH_ADDR_B;
        end
        PH_ADDR_B: begin
          rec_sum += b;
          rec_phase = PH_TYPE;
        end
        PH_TYPE: begin
          rec_type = b;
          rec_phase = (rec_len != 0) ? PH_DATA : PH_CSUM;
        end
        PH_DATA: begin
          // bytes past the record buffer still count toward the sum
          if (rec_count < RECORD_BYTES) rec_buf[rec_count] = b;
          rec_sum += b;
          rec_count++;
          if (rec_count >= rec_len) rec_phase = PH_CSUM;
        end
        PH_CSUM: begin
          rec_phase = PH_IDLE;
          if (rec_type == code_final) begin
            // end of image: type alone decides, checksum ignored
            emit_page(1'b0, 1'b1);
            rec_phase = PH_OVER;
          end else if (rec_len > RECORD_BYTES || 8'(8'h00 - rec_sum) != b) begin
            push_reply(code_resend);
            push_reply(code_ready);
          end else begin
            for (int k = 0; k < rec_len && k < RECORD_BYTES; k++) begin
              if (page_fill < PAGE_BYTES) begin
                page_buf[page_fill] = rec_buf[k];
                page_fill++;
              end
            end
            if (page_fill >= PAGE_BYTES) emit_page(1'b1, 1'b0);
            else push_reply(code_ready);
          end
        end
        default: ;
      endcase
    end
    if (reply_word_q.size() > owed_before) reply_word_q[reply_word_q.size() - 1].last = 1'b1;
  endtask

  // track register writes and accepted input transactions at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_loader_copy();
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_count++;
        case (cfg_index)
          CFG_START_CODE:   code_start = cfg_data[7:0];
          CFG_READY_CODE:   code_ready = cfg_data[7:0];
          CFG_RESEND_CODE:  code_resend = cfg_data[7:0];
          CFG_FINAL_TYPE:   code_final = cfg_data[7:0];
          CFG_BASE_ADDRESS: base_addr = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        link_count++;
        parse_link_byte(in_kind, in_rx_byte);
      end
    end
  end

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (out_word_valid) word_count++;
      if (reply_word_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual tx %b/%h word %b %h@%h",
                 $time, out_tx_valid, out_tx_byte, out_word_valid, out_flash_word,
                 out_word_address);
        errors++;
      end else begin
        want = reply_word_q.pop_front();
        check_field("tx_valid", 16'(want.tx_valid), 16'(out_tx_valid));
        check_field("tx_byte", 16'(want.tx_byte), 16'(out_tx_byte));
        check_field("word_valid", 16'(want.word_valid), 16'(out_word_valid));
        check_field("word_address", want.word_address, out_word_address);
        check_field("flash_word", want.flash_word, out_flash_word);
        check_field("page_end", 16'(want.page_end), 16'(out_page_end));
        check_field("image_end", 16'(want.image_end), 16'(out_image_end));
        check_field("last", 16'(want.last), 16'(out_last));
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // one input transaction; random idle cycles in front, held while stalled
  task automatic send_link(input logic kind, input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic new_session();
    send_link(1'b1, 8'($urandom));
  endtask

  // full record: start, length, address, type, data, checksum
  task automatic send_record(input logic [7:0] typ, input link_bytes_t data, input bit bad_sum);
    logic [7:0] len, addr_hi, addr_lo, sum, csum;
    len = 8'(data.size());
    addr_hi = 8'($urandom);
    addr_lo = 8'($urandom);
    sum = len + addr_hi + addr_lo;
    foreach (data[k]) sum += data[k];
    csum = 8'h00 - sum;
    if (bad_sum) csum = csum ^ 8'($urandom_range(1, 255));
    send_link(1'b0, cur_start);
    send_link(1'b0, len);
    send_link(1'b0, addr_hi);
    send_link(1'b0, addr_lo);
    send_link(1'b0, typ);
    foreach (data[k]) send_link(1'b0, data[k]);
    send_link(1'b0, csum);
  endtask

  function automatic link_bytes_t rand_bytes(input int n);
    link_bytes_t q;
    for (int k = 0; k < n; k++) q.push_back(8'($urandom));
    return q;
  endfunction

  function automatic link_bytes_t const_bytes(input int n, input logic [7:0] value);
    link_bytes_t q;
    for (int k = 0; k < n; k++) q.push_back(value);
    return q;
  endfunction

  // any record type except the end-of-image one
  function automatic logic [7:0] plain_type();
    logic [7:0] t;
    t = 8'($urandom);
    if (t == cur_final) t = ~t;
    return t;
  endfunction

  // drop valid, let every owed result drain, then wait for the loader to
  // finish bytes that produce nothing
  task automatic wait_settled();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (reply_word_q.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    if (reply_word_q.size() != 0) begin
      $display("%0t ns: %0d results never arrived, expected tx %b/%h word %b",
               $time, reply_word_q.size(), reply_word_q[0].tx_valid,
               reply_word_q[0].tx_byte, reply_word_q[0].word_valid);
      errors += reply_word_q.size();
      reply_word_q.delete();
    end
    repeat (16) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IW-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // writes every register, junk in the unused upper bits of byte registers,
  // plus one write to an index past the register list that must be ignored
  task automatic apply_settings(input logic [7:0] start, input logic [7:0] ready,
                                input logic [7:0] resend, input logic [7:0] fin,
                                input logic [15:0] base);
    put_reg(CFG_START_CODE, {8'($urandom), start});
    put_reg(CFG_READY_CODE, {8'($urandom), ready});
    put_reg(CFG_RESEND_CODE, {8'($urandom), resend});
    put_reg(CFG_FINAL_TYPE, {8'($urandom), fin});
    put_reg(CFG_BASE_ADDRESS, base);
    put_reg(CFG_IW'($urandom_range(int'(CFG_BASE_ADDRESS) + 1, (1 << CFG_IW) - 1)),
            16'($urandom));
    cfg_valid <= 1'b0;
    cur_start = start;
    cur_final = fin;
  endtask

  // mostly well-formed records with random content, some broken ones and noise
  task automatic random_traffic(input int n_items);
    int sent, pick, len;
    logic [7:0] b;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // normal record, full length favored so pages fill up
        len = ($urandom_range(3) == 0) ? RECORD_BYTES : $urandom_range(RECORD_BYTES);
        send_record(plain_type(), rand_bytes(len), $urandom_range(9) == 0);
        sent += len + 6;
      end else if (pick < 78) begin
        // over-long record, now and then the longest one
        len = ($urandom_range(7) == 0) ? 255 : $urandom_range(RECORD_BYTES + 1, 3 * RECORD_BYTES);
        send_record(plain_type(), rand_bytes(len), $urandom_range(3) == 0);
        sent += len + 6;
      end else if (pick < 84) begin
        // end of image, bytes while the session is over, then restart
        len = $urandom_range(RECORD_BYTES + 4);
        send_record(cur_final, rand_bytes(len), $urandom_range(1) == 0);
        repeat ($urandom_range(3)) send_link(1'b0, 8'($urandom));
        new_session();
        sent += len + 7;
      end else if (pick < 90) begin
        // record cut short by a restart
        len = $urandom_range(1, 5);
        send_link(1'b0, cur_start);
        repeat (len) send_link(1'b0, 8'($urandom));
        new_session();
        sent += len + 2;
      end else if (pick < 96) begin
        // stray byte between records
        b = 8'($urandom);
        if (b == cur_start) b = ~b;
        send_link(1'b0, b);
        sent += 1;
      end else begin
        new_session();
        sent += 1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // no restart yet: noise ignored, first record answered with default ready
  task automatic test_after_reset();
    idle_pct = 0;
    stall_pct = 0;
    send_link(1'b0, 8'h00);
    send_link(1'b0, 8'hFF);
    send_record(8'h00, const_bytes(2, 8'hFF), 1'b0);
  endtask

  // restart, empty / full-length / bad / over-long / truncated records
  task automatic test_records();
    new_session();
    send_record(8'h00, rand_bytes(0), 1'b0);
    send_record(plain_type(), const_bytes(RECORD_BYTES, 8'hFF), 1'b0);
    send_record(8'hFF, const_bytes(1, 8'h00), 1'b1);
    send_record(plain_type(), rand_bytes(RECORD_BYTES + 1), 1'b0);
    send_link(1'b0, cur_start);
    send_link(1'b0, 8'd4);
    send_link(1'b0, 8'h12);
    send_link(1'b1, 8'hFF);
    send_record(plain_type(), rand_bytes(3), 1'b0);
  endtask

  // end-of-image flush of a partial page and of an empty page
  task automatic test_final_record();
    send_record(plain_type(), rand_bytes(5), 1'b0);
    send_record(cur_final, rand_bytes(2), 1'b1);
    // session over: this whole record is ignored
    send_record(plain_type(), rand_bytes(2), 1'b0);
    new_session();
    send_record(cur_final, rand_bytes(0), 1'b0);
    new_session();
  endtask

  // eight records of 15 leave 120 bytes, the ninth spills past the page end
  task automatic test_page_fill();
    idle_pct = 0;
    stall_pct = 76;
    new_session();
    repeat (9) send_record(plain_type(), rand_bytes(15), 1'b0);
    send_record(plain_type(), rand_bytes(RECORD_BYTES), 1'b0);
    send_record(cur_final, rand_bytes(1), 1'b0);
    new_session();
  endtask

  // page starting near the top of the address space wraps to zero
  task automatic test_address_wrap();
    wait_settled();
    apply_settings(DEF_START, DEF_READY, DEF_RESEND, DEF_FINAL, 16'hFFC0);
    idle_pct = 76;
    stall_pct = 0;
    new_session();
    send_record(plain_type(), rand_bytes(RECORD_BYTES), 1'b0);
    send_record(plain_type(), rand_bytes(7), 1'b0);
    send_record(cur_final, rand_bytes(0), 1'b0);
    new_session();
  endtask

  task automatic test_random_phase(input logic [7:0] start, input logic [7:0] ready,
                                   input logic [7:0] resend, input logic [7:0] fin,
                                   input logic [15:0] base, input int send_idle,
                                   input int recv_stall);
    wait_settled();
    apply_settings(start, ready, resend, fin, base);
    idle_pct = send_idle;
    stall_pct = recv_stall;
    new_session();
    random_traffic(20);
  endtask

  // --------------------------------------------------------------------------
  // run
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_records();
    test_final_record();
    test_page_fill();
    test_address_wrap();

    // default codes, no throttling
    test_random_phase(DEF_START, DEF_READY, DEF_RESEND, DEF_FINAL, DEF_BASE, 0, 0);
    // all-low codes but a high resend code, sender mostly idle
    test_random_phase(8'h00, 8'h00, 8'hFF, 8'h00, 16'h0000, 76, 0);
    // all-high codes but a low resend code, receiver mostly stalled
    test_random_phase(8'hFF, 8'hFF, 8'h00, 8'hFF, 16'hFFFF, 0, 76);
    // random codes, light throttling on both sides
    test_random_phase(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      16'($urandom), 6, 6);

    wait_settled();
    $display("covered %0d link transactions and %0d register writes", link_count, cfg_count);
    $display("checked %0d results, %0d of them flash words, %0d mismatches",
             result_count, word_count, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
